// File: sv/lbs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and a saturating add for the skinning block
package lbs_pkg;
   localparam int DefMaxJoints = 64;
   localparam int IdxW = 6;
   localparam int PosW = 32;
   localparam int DirW = 16;
   localparam int AccPW = 48;
   localparam int AccNW = 32;
   localparam logic ActLoad = 1'b0;
   localparam logic ActInfl = 1'b1;

   typedef struct packed {
      logic signed [PosW-1:0] tx, ty, tz;
      logic signed [DirW-1:0] qw, qx, qy, qz;
   } joint_type;

   typedef struct packed {
      logic signed [PosW-1:0] px, py, pz;
      logic signed [DirW-1:0] nx, ny, nz;
      logic [15:0] wt;
      logic        last;
      logic        hit;
   } infl_type;

   function automatic logic signed [AccPW-1:0] sat_add48(
      input logic signed [AccPW-1:0] a, input logic signed [AccPW-1:0] b);
      logic signed [AccPW:0] s;
      begin
         s = {a[AccPW-1], a} + {b[AccPW-1], b};
         if (s[AccPW] != s[AccPW-1])
            sat_add48 = s[AccPW] ? {1'b1, {(AccPW-1){1'b0}}} : {1'b0, {(AccPW-1){1'b1}}};
         else
            sat_add48 = s[AccPW-1:0];
      end
   endfunction
endpackage

// File: sv/lbs_joint_mem.sv
`timescale 1ns / 1ps
// joint table memory with registered read
module lbs_joint_mem import lbs_pkg::*; #(
   parameter int MAX_JOINTS = DefMaxJoints
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_JOINTS)-1:0] wr_addr,
   input  joint_type                     wr_data,
   input  logic [$clog2(MAX_JOINTS)-1:0] rd_addr,
   output joint_type                     rd_data
);
   joint_type mem [MAX_JOINTS];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/lbs_datapath.sv
`timescale 1ns / 1ps
// rotation matrix, rotate, weight and accumulate, each step registered in turn
module lbs_datapath import lbs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  infl_type  infl,
   input  joint_type jnt,
   output logic      done,
   output logic [PosW-1:0] out_px, out_py, out_pz,
   output logic [DirW-1:0] out_nx, out_ny, out_nz
);
   logic [3:0] stage_ff;
   logic signed [19:0] r_ff [3][3];
   logic signed [47:0] rp_ff [3];
   logic signed [31:0] rn_ff [3];
   logic signed [47:0] wp [3];
   logic signed [47:0] wn [3];
   logic signed [AccPW-1:0] accp_ff [3];
   logic signed [AccNW-1:0] accn_ff [3];
   infl_type infl_ff;
   joint_type j_ff;

   logic signed [19:0] m [3][3];
   always_comb begin
      logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
      xx = 34'(j_ff.qx * j_ff.qx);
      yy = 34'(j_ff.qy * j_ff.qy); zz = 34'(j_ff.qz * j_ff.qz);
      xy = 34'(j_ff.qx * j_ff.qy); xz = 34'(j_ff.qx * j_ff.qz);
      yz = 34'(j_ff.qy * j_ff.qz); wx = 34'(j_ff.qw * j_ff.qx);
      wy = 34'(j_ff.qw * j_ff.qy); wz = 34'(j_ff.qw * j_ff.qz);
      one = 34'sd1 <<< 28;
      m[0][0] = 20'((one - 2*(yy+zz) + 34'sd8192) >>> 14);
      m[0][1] = 20'((2*(xy-wz) + 34'sd8192) >>> 14);
      m[0][2] = 20'((2*(xz+wy) + 34'sd8192) >>> 14);
      m[1][0] = 20'((2*(xy+wz) + 34'sd8192) >>> 14);
      m[1][1] = 20'((one - 2*(xx+zz) + 34'sd8192) >>> 14);
      m[1][2] = 20'((2*(yz-wx) + 34'sd8192) >>> 14);
      m[2][0] = 20'((2*(xz-wy) + 34'sd8192) >>> 14);
      m[2][1] = 20'((2*(yz+wx) + 34'sd8192) >>> 14);
      m[2][2] = 20'((one - 2*(xx+yy) + 34'sd8192) >>> 14);
   end

   logic signed [67:0] sp [3];
   logic signed [51:0] sn [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sp[i] = 68'(r_ff[i][0] * infl_ff.px) + 68'(r_ff[i][1] * infl_ff.py)
               + 68'(r_ff[i][2] * infl_ff.pz) + 68'sd8192;
         sn[i] = 52'(r_ff[i][0] * infl_ff.nx) + 52'(r_ff[i][1] * infl_ff.ny)
               + 52'(r_ff[i][2] * infl_ff.nz) + 52'sd8192;
      end
   end

   logic signed [47:0] tr [3];
   assign tr[0] = 48'(j_ff.tx);
   assign tr[1] = 48'(j_ff.ty);
   assign tr[2] = 48'(j_ff.tz);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            accp_ff[i] <= '0;
            accn_ff[i] <= '0;
         end
      end else begin
         stage_ff <= {stage_ff[2:0], start};
         if (stage_ff[3]) begin
            for (int i = 0; i < 3; i++) begin
               logic signed [AccPW-1:0] s;
               s = sat_add48(48'(accn_ff[i]), infl_ff.hit ? wn[i] : 48'sd0);
               if (infl_ff.last) begin
                  accp_ff[i] <= '0;
                  accn_ff[i] <= '0;
               end else begin
                  if (infl_ff.hit) accp_ff[i] <= sat_add48(accp_ff[i], wp[i]);
                  if (s > 48'sd2147483647) accn_ff[i] <= 32'h7fffffff;
                  else if (s < -48'sd2147483648) accn_ff[i] <= 32'h80000000;
                  else accn_ff[i] <= s[31:0];
               end
            end
         end
      end
   end

   // output saturation from the final sums
   logic signed [AccPW-1:0] fp [3];
   logic signed [AccPW-1:0] fn [3];
   logic [PosW-1:0] op [3];
   logic [DirW-1:0] on [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [AccPW-1:0] t;
         fp[i] = infl_ff.hit ? sat_add48(accp_ff[i], wp[i]) : accp_ff[i];
         t = sat_add48(48'(accn_ff[i]), infl_ff.hit ? wn[i] : 48'sd0);
         if (t > 48'sd2147483647) fn[i] = 48'sd2147483647;
         else if (t < -48'sd2147483648) fn[i] = -48'sd2147483648;
         else fn[i] = t;
         if (fp[i] > 48'sd2147483647) op[i] = 32'h7fffffff;
         else if (fp[i] < -48'sd2147483648) op[i] = 32'h80000000;
         else op[i] = fp[i][31:0];
         if (fn[i] > 48'sd32767) on[i] = 16'h7fff;
         else if (fn[i] < -48'sd32768) on[i] = 16'h8000;
         else on[i] = fn[i][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) infl_ff <= infl;
      if (stage_ff[0]) begin
         j_ff <= jnt;
      end
      if (stage_ff[1]) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) r_ff[i][k] <= m[i][k];
      end
      if (stage_ff[2]) begin
         for (int i = 0; i < 3; i++) begin
            rp_ff[i] <= 48'(sp[i] >>> 14) + tr[i];
            rn_ff[i] <= 32'(sn[i] >>> 14);
         end
      end
      if (done) begin
         out_px <= op[0]; out_py <= op[1]; out_pz <= op[2];
         out_nx <= on[0]; out_ny <= on[1]; out_nz <= on[2];
      end
   end

   // weight products feeding the accumulate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wp[i] = 48'((66'(rp_ff[i]) * $signed({1'b0, infl_ff.wt}) + 66'sd16384) >>> 15);
         wn[i] = 48'((50'(rn_ff[i]) * $signed({1'b0, infl_ff.wt}) + 50'sd16384) >>> 15);
      end
   end

   assign done = stage_ff[3] && infl_ff.last;
endmodule

// File: sv/linear_blend_skinning.sv
`timescale 1ns / 1ps
// Linear blend skinning top level. A load word writes one joint entry. An
// influence word passes five steps: joint memory read, joint register, matrix
// build, rotation, weighting into the accumulators, on the single rotation
// datapath; no word is taken until it is through. A result word waits in an
// output register; words that do not close a vertex are still taken while it
// waits, and the closing influence is held until the result has left.
module linear_blend_skinning import lbs_pkg::*; #(
   parameter int MAX_JOINTS = DefMaxJoints
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action, joint_index, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z, quat_w, weight, pad
   input  logic [183:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x, skin_nrm_y, skin_nrm_z
   output logic [143:0] rsp_tdata
);
   localparam int AW = $clog2(MAX_JOINTS);
   logic       act;
   logic [IdxW-1:0] idx;
   logic [AW-1:0] addr;
   logic       hit;
   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff;
   logic       rv_ff;
   logic       done;
   joint_type  wj, rj;
   infl_type   inf;
   logic       acc;
   logic [PosW-1:0] px, py, pz;
   logic [DirW-1:0] nx, ny, nz;

   assign act = req_tdata[0];
   assign idx = req_tdata[6:1];
   assign addr = AW'(idx);
   assign hit = 32'(idx) < MAX_JOINTS;
   assign req_tready = !busy_ff && !(rv_ff && act == ActInfl && req_tlast);
   assign acc = req_tvalid && req_tready;
   assign wj.tx = req_tdata[38:7];
   assign wj.ty = req_tdata[70:39];
   assign wj.tz = req_tdata[102:71];
   assign wj.qx = req_tdata[118:103];
   assign wj.qy = req_tdata[134:119];
   assign wj.qz = req_tdata[150:135];
   assign wj.qw = req_tdata[166:151];
   assign inf.px = wj.tx;
   assign inf.py = wj.ty;
   assign inf.pz = wj.tz;
   assign inf.nx = wj.qx;
   assign inf.ny = wj.qy;
   assign inf.nz = wj.qz;
   assign inf.wt = req_tdata[182:167];
   assign inf.last = req_tlast;
   assign inf.hit = hit;
   assign busy_in = busy_ff ? (cnt_ff != 3'd4) : (acc && act == ActInfl);

   lbs_joint_mem #(.MAX_JOINTS(MAX_JOINTS)) u_mem (
      .clock, .wr_en(acc && act == ActLoad && hit), .wr_addr(addr),
      .wr_data(wj), .rd_addr(addr), .rd_data(rj));

   lbs_datapath u_dp (
      .clock, .reset, .start(acc && act == ActInfl), .infl(inf), .jnt(rj),
      .done, .out_px(px), .out_py(py), .out_pz(pz),
      .out_nx(nx), .out_ny(ny), .out_nz(nz));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= busy_ff ? cnt_ff + 3'd1 : 3'd0;
         if (done) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {nz, ny, nx, pz, py, px};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !acc) else $error("word taken while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("result without work");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff) else $error("result dropped");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !rv_ff) else $error("result overwritten");
endmodule
